@@ design/p2rle_pkg.sv @@
// Shared types, constants and pixel conversion for the RGB565 RLE encoder.
`default_nettype none
package p2rle_pkg;

  localparam int MAX_PIXELS = 2097152;
  localparam int LIT_DEPTH = 128;
  localparam int LIT_AW = $clog2(LIT_DEPTH);
  localparam int LIT_CW = 8;
  localparam int RUN_CW = 8;
  localparam int PIX_CW = 22;
  localparam int BYTE_CW = 23;
  localparam int ODATA_W = 96;
  localparam logic [RUN_CW-1:0] RUN_LAST = 8'd128;
  localparam logic [RUN_CW-1:0] RUN_HDR_OFS = 8'd126;
  localparam logic [BYTE_CW-1:0] BYTE_SAT = 23'h7FFFFF;
  localparam logic [PIX_CW-1:0] PIX_MAX = PIX_CW'(MAX_PIXELS);

  typedef enum logic [1:0] {
    FMT_1555 = 2'd0,
    FMT_8888 = 2'd1,
    FMT_RGBA = 2'd2,
    FMT_565  = 2'd3
  } fmt_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EOF, S_RHDR, S_RLO, S_RHI, S_LHDR, S_LRD, S_LLO, S_LHI, S_FIN
  } state_t;

  typedef struct packed {
    logic               bvalid;
    logic [7:0]         bdata;
    logic               fin;
    logic               eof;
    logic [BYTE_CW-1:0] total;
    logic               oversize;
  } pack_cmd_t;

  typedef struct packed {
    logic bready;
    logic fin_ack;
  } pack_ack_t;

  function automatic logic [15:0] to_rgb565(input fmt_t fmt, input logic [31:0] v);
    logic [15:0] r;
    begin
      case (fmt)
        FMT_1555: r = {v[14:10], v[9:5], 1'b0, v[4:0]};
        FMT_8888: r = {v[23:19], v[15:10], v[7:3]};
        FMT_RGBA: r = {v[7:3], v[15:10], v[23:19]};
        default:  r = v[15:0];
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ design/p2rle_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module p2rle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/p2rle_pack.sv @@
// Byte packer: eight bytes per word, one-word hold for end-of-step marking, output register.
`default_nettype none
module p2rle_pack (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire p2rle_pkg::pack_cmd_t            cmd,
  output p2rle_pkg::pack_ack_t                 ack,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [p2rle_pkg::ODATA_W-1:0]        m_tdata,
  output logic                                 m_tlast,
  output logic [1:0]                           m_tuser
);

  logic [63:0] res;
  logic [3:0]  cnt;
  logic        pv;
  logic [63:0] pd;
  logic [3:0]  pc;
  logic        ov;
  logic [63:0] od;
  logic [3:0]  oc;
  logic        olast;
  logic        odone;
  logic [p2rle_pkg::BYTE_CW-1:0] obytes;
  logic        oover;
  logic        flush_w;
  logic        out_free;
  logic        out_load;

  assign flush_w = (cnt == 4'd8) || (cmd.fin && cmd.eof && (cnt != 4'd0));
  assign out_free = !ov || m_tready;
  assign ack.bready = !cnt[3];
  assign ack.fin_ack = cmd.fin && !flush_w && (!pv || out_free);
  assign out_load = pv && ((flush_w && out_free) || (!flush_w && ack.fin_ack));

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
      cnt <= '0;
      pv <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (ov && m_tready && !out_load) begin
        ov <= 1'b0;
      end
      if (flush_w) begin
        if (!pv) begin
          pd <= res;
          pc <= cnt;
          pv <= 1'b1;
          res <= '0;
          cnt <= '0;
        end else if (out_free) begin
          ov <= 1'b1;
          od <= pd;
          oc <= pc;
          olast <= 1'b0;
          odone <= 1'b0;
          obytes <= '0;
          oover <= 1'b0;
          pd <= res;
          pc <= cnt;
          res <= '0;
          cnt <= '0;
        end
      end else if (ack.fin_ack) begin
        if (pv) begin
          ov <= 1'b1;
          od <= pd;
          oc <= pc;
          olast <= 1'b1;
          odone <= cmd.eof;
          obytes <= cmd.eof ? cmd.total : '0;
          oover <= cmd.eof && cmd.oversize;
          pv <= 1'b0;
        end
      end else if (cmd.bvalid && ack.bready) begin
        res[{cnt[2:0], 3'b000} +: 8] <= cmd.bdata;
        cnt <= cnt + 4'd1;
      end
    end
  end

  assign m_tvalid = ov;
  assign m_tdata = {5'b0, obytes, oc, od};
  assign m_tlast = odone;
  assign m_tuser = {oover, olast};

endmodule
`default_nettype wire

@@ design/pixel_to_rgb565_rle_encoder.sv @@
// Top level: RGB565 conversion and PackBits-style RLE sequencer.
// A pixel that emits nothing steps through accept, eof check and finish; emitting a run adds
// header, low and high byte states, and a literal flush adds a header and then a read, low and high
// byte state per stored pixel; byte states stall on output. The next pixel waits for idle.
// Reset: synchronous, clears all frame state; source_format returns to RGB565.
`default_nettype none
module pixel_to_rgb565_rle_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // source_pixel[31:0]
  input  wire logic        s_tlast,   // end_of_frame
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // packed_bytes[63:0], byte_count[67:64], frame_bytes[90:68]
  output logic             m_tlast,   // frame_done
  output logic [1:0]       m_tuser    // last_of_step[0], frame_oversize[1]
);

  p2rle_pkg::state_t state, state_next, ret, ret_next;
  p2rle_pkg::fmt_t fmt;
  logic [15:0] rp, rp_next, em_px, em_px_next, px, rdata;
  logic [p2rle_pkg::RUN_CW-1:0] rl, rl_next, em_len, em_len_next;
  logic [p2rle_pkg::LIT_CW-1:0] lit, lit_next;
  logic [p2rle_pkg::LIT_AW-1:0] idx, idx_next;
  logic eof_r, eof_next, accept, we;
  logic [p2rle_pkg::PIX_CW-1:0] pix_cnt, pix_next;
  logic [p2rle_pkg::BYTE_CW-1:0] byte_tot;
  p2rle_pkg::pack_cmd_t cmd;
  p2rle_pkg::pack_ack_t ack;

  assign s_tready = (state == p2rle_pkg::S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign px = p2rle_pkg::to_rgb565(fmt, s_tdata);

  always_comb begin
    state_next = state;
    ret_next = ret;
    rp_next = rp;
    rl_next = rl;
    em_px_next = em_px;
    em_len_next = em_len;
    lit_next = lit;
    idx_next = idx;
    eof_next = eof_r;
    pix_next = pix_cnt;
    we = 1'b0;
    cmd = '0;
    cmd.eof = eof_r;
    cmd.total = byte_tot;
    cmd.oversize = (pix_cnt > p2rle_pkg::PIX_MAX);
    case (state)
      p2rle_pkg::S_IDLE: begin
        if (accept) begin
          eof_next = s_tlast;
          if (pix_cnt <= p2rle_pkg::PIX_MAX) begin
            pix_next = pix_cnt + 1'b1;
          end
          ret_next = p2rle_pkg::S_EOF;
          if (rl == '0) begin
            rp_next = px;
            rl_next = 8'd1;
            state_next = p2rle_pkg::S_EOF;
          end else if (px == rp) begin
            rl_next = rl + 8'd1;
            if (rl == 8'd1 && lit != '0) begin
              state_next = p2rle_pkg::S_LHDR;
            end else if (rl == p2rle_pkg::RUN_LAST) begin
              em_px_next = rp;
              em_len_next = rl + 8'd1;
              rl_next = '0;
              state_next = p2rle_pkg::S_RHDR;
            end else begin
              state_next = p2rle_pkg::S_EOF;
            end
          end else begin
            rp_next = px;
            rl_next = 8'd1;
            if (rl >= 8'd2) begin
              em_px_next = rp;
              em_len_next = rl;
              state_next = p2rle_pkg::S_RHDR;
            end else begin
              we = 1'b1;
              lit_next = lit + 8'd1;
              state_next = (lit_next == 8'(p2rle_pkg::LIT_DEPTH)) ?
                           p2rle_pkg::S_LHDR : p2rle_pkg::S_EOF;
            end
          end
        end
      end
      p2rle_pkg::S_EOF: begin
        if (!eof_r) begin
          state_next = p2rle_pkg::S_FIN;
        end else begin
          ret_next = p2rle_pkg::S_FIN;
          rl_next = '0;
          if (rl >= 8'd2) begin
            em_px_next = rp;
            em_len_next = rl;
            state_next = p2rle_pkg::S_RHDR;
          end else if (rl == 8'd1) begin
            we = 1'b1;
            lit_next = lit + 8'd1;
            state_next = p2rle_pkg::S_LHDR;
          end else begin
            state_next = (lit != '0) ? p2rle_pkg::S_LHDR : p2rle_pkg::S_FIN;
          end
        end
      end
      p2rle_pkg::S_RHDR: begin
        cmd.bvalid = 1'b1;
        cmd.bdata = em_len + p2rle_pkg::RUN_HDR_OFS;
        if (ack.bready) state_next = p2rle_pkg::S_RLO;
      end
      p2rle_pkg::S_RLO: begin
        cmd.bvalid = 1'b1;
        cmd.bdata = em_px[7:0];
        if (ack.bready) state_next = p2rle_pkg::S_RHI;
      end
      p2rle_pkg::S_RHI: begin
        cmd.bvalid = 1'b1;
        cmd.bdata = em_px[15:8];
        if (ack.bready) state_next = ret;
      end
      p2rle_pkg::S_LHDR: begin
        cmd.bvalid = 1'b1;
        cmd.bdata = lit - 8'd1;
        if (ack.bready) begin
          idx_next = '0;
          state_next = p2rle_pkg::S_LRD;
        end
      end
      p2rle_pkg::S_LRD: begin
        state_next = p2rle_pkg::S_LLO;
      end
      p2rle_pkg::S_LLO: begin
        cmd.bvalid = 1'b1;
        cmd.bdata = rdata[7:0];
        if (ack.bready) state_next = p2rle_pkg::S_LHI;
      end
      p2rle_pkg::S_LHI: begin
        cmd.bvalid = 1'b1;
        cmd.bdata = rdata[15:8];
        if (ack.bready) begin
          if ({1'b0, idx} + 8'd1 == lit) begin
            lit_next = '0;
            state_next = ret;
          end else begin
            idx_next = idx + 1'b1;
            state_next = p2rle_pkg::S_LRD;
          end
        end
      end
      p2rle_pkg::S_FIN: begin
        cmd.fin = 1'b1;
        if (ack.fin_ack) begin
          state_next = p2rle_pkg::S_IDLE;
          if (eof_r) begin
            rp_next = '0;
            rl_next = '0;
            lit_next = '0;
            pix_next = '0;
          end
        end
      end
      default: state_next = p2rle_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= p2rle_pkg::S_IDLE;
      ret <= p2rle_pkg::S_IDLE;
      fmt <= p2rle_pkg::FMT_565;
      rp <= '0;
      rl <= '0;
      lit <= '0;
      idx <= '0;
      eof_r <= 1'b0;
      pix_cnt <= '0;
      byte_tot <= '0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      if (cfg_we) fmt <= p2rle_pkg::fmt_t'(cfg_data);
      rp <= rp_next;
      rl <= rl_next;
      lit <= lit_next;
      idx <= idx_next;
      eof_r <= eof_next;
      pix_cnt <= pix_next;
      if (state == p2rle_pkg::S_FIN && ack.fin_ack && eof_r) begin
        byte_tot <= '0;
      end else if (cmd.bvalid && ack.bready && byte_tot != p2rle_pkg::BYTE_SAT) begin
        byte_tot <= byte_tot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    em_px <= em_px_next;
    em_len <= em_len_next;
  end

  p2rle_ram #(.WIDTH(16), .DEPTH(p2rle_pkg::LIT_DEPTH)) u_lit (
    .clk   (clk),
    .we    (we),
    .waddr (lit[p2rle_pkg::LIT_AW-1:0]),
    .wdata (rp),
    .raddr (idx),
    .rdata (rdata)
  );

  p2rle_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .ack      (ack),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

@@ design/p2rle_chk.sv @@
// Port-level checker for the RGB565 RLE encoder, bound to the top level.
`default_nettype none
module p2rle_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic [1:0]  m_tuser
);

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[67:64] != 4'd0) && (m_tdata[67:64] <= 4'd8))
    else $error("byte_count out of range");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[0])
    else $error("frame_done without last_of_step");

  a_tot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[90:68] == 23'd0) && !m_tuser[1])
    else $error("frame total on non-final transfer");

  a_partial: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[67:64] != 4'd8) |-> m_tlast)
    else $error("partial word before frame end");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind pixel_to_rgb565_rle_encoder p2rle_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire
